@@ rtl/gdda_pkg.sv @@
package gdda_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 22;
  localparam int DIR_W     = 19;
  localparam int MAG_W     = DIR_W;
  localparam int QUO_W     = 2 * FRAC_BITS + 1;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int HI_W      = QUO_W - FRAC_BITS;
  localparam int PROD_W    = FRAC_W + HI_W;
  localparam int CELL_W    = 6;
  localparam int DIST_W    = 24;
  localparam int SIZE_W    = 7;
  localparam int STAT_W    = 2;

  localparam int GRID_SIZE_DEF = 64;
  localparam int MAX_STEPS_DEF = 128;

  localparam logic [FRAC_W-1:0] ONE_FIX  = FRAC_W'(1) << FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Stream payload layout
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 40;
  localparam int IN_CX_LSB   = 0;
  localparam int IN_CY_LSB   = IN_CX_LSB + CELL_W;
  localparam int IN_WALL_LSB = IN_CY_LSB + CELL_W;
  localparam int IN_PX_LSB   = IN_WALL_LSB + 1;
  localparam int IN_PY_LSB   = IN_PX_LSB + POS_W;
  localparam int IN_DX_LSB   = IN_PY_LSB + POS_W;
  localparam int IN_DY_LSB   = IN_DX_LSB + DIR_W;
  localparam int OUT_USED_W  = DIST_W + 1 + 2 * CELL_W;

  // Codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_HIT   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAP_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAP_HEIGHT = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_MUL,
    S_START,
    S_WALK,
    S_TEST,
    S_DONE
  } gdda_state_t;

endpackage

@@ rtl/grid_dda_ray_caster_unit.sv @@
// Grid ray caster (DDA walk over a one-bit wall map).
// Input stream: in_tuser selects the request kind (0 writes one map cell,
// 1 casts one ray); in_tdata carries cell, position and direction fields.
// A cell write gives no result. A cast gives one
// result on the output stream: distance, side and hit cell in out_tdata,
// status in out_tuser.
// Cast setup: two reciprocals on the shared divider, four passes of the
// shared 17x17 multiplier, then the start check. Each grid step is the
// step, then the registered map read. The walk ends on a wall hit, when it
// leaves the map or at the step limit; a cast that starts off the map
// skips the walk. in_tready is low while a cast is in flight and rises in
// the cycle after the result is loaded. After reset the map RAM is swept to
// zero, all GRID_SIZE*GRID_SIZE cells (4096 by default), with in_tready low;
// APB writes are taken meanwhile. If the receiver stalls, the next request
// is still taken and only its completion waits for the output register.
// APB: map_width at 0x0, map_height at 0x4; both reset to 64.
module grid_dda_ray_caster_unit import gdda_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cell_x, cell_y, cell_wall, pos_x, pos_y, dir_x, dir_y, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // wall_distance, wall_side, hit_x, hit_y, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [STAT_W-1:0]      out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int AW     = $clog2(DEPTH);
  localparam int SZW    = $clog2(GRID_SIZE + 1);
  localparam int EW     = (SZW > SIZE_W) ? SZW : SIZE_W;
  localparam int CW     = EW + 1;
  localparam int NW     = $clog2(MAX_STEPS + 1);
  localparam int SIDE_W = QUO_W + $clog2(MAX_STEPS + 2) + 1;

  gdda_state_t state_r, state_nxt;

  // Configuration
  logic [SIZE_W-1:0] map_width_r, map_height_r;
  logic              cfg_wr;
  logic [EW-1:0]     w_eff, h_eff;

  // Cast operands
  logic [CW-1:0]      mx_r, my_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic               dx_neg_r, dy_neg_r, dx_zero_r, dy_zero_r;
  logic [MAG_W-1:0]   adx_r, ady_r;
  logic [QUO_W-1:0]   delta_x_r, delta_y_r;
  logic [SIDE_W-1:0]  side_x_r, side_y_r;
  logic [2:0]         mcnt_r;
  logic [PROD_W-1:0]  prod_r;
  logic [NW-1:0]      n_r;
  logic               side_r;
  logic [STAT_W-1:0]  status_r;
  logic [AW-1:0]      clr_r;

  // Output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [STAT_W-1:0]      out_user_r;

  // Shared units
  logic             div_start, div_busy;
  logic [MAG_W-1:0] div_mag;
  logic [QUO_W-1:0] div_quo;
  logic [FRAC_W-1:0] mul_a, mul_b, frac_x, frac_y;

  // Map RAM
  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;

  // Step
  logic          take_x, n_out, at_limit, out_free, in_acc;
  logic [CW-1:0] nmx, nmy;
  logic [SIDE_W-1:0] dist_raw;
  logic [DIST_W-1:0] dist_sat;

  // Input fields
  logic [CELL_W-1:0] f_cx, f_cy;
  logic              f_wall;
  logic [POS_W-1:0]  f_px, f_py;
  logic [DIR_W-1:0]  f_dx, f_dy;

  assign f_cx   = in_tdata[IN_CX_LSB +: CELL_W];
  assign f_cy   = in_tdata[IN_CY_LSB +: CELL_W];
  assign f_wall = in_tdata[IN_WALL_LSB];
  assign f_px   = in_tdata[IN_PX_LSB +: POS_W];
  assign f_py   = in_tdata[IN_PY_LSB +: POS_W];
  assign f_dx   = in_tdata[IN_DX_LSB +: DIR_W];
  assign f_dy   = in_tdata[IN_DY_LSB +: DIR_W];

  assign in_acc = in_tvalid && in_tready;

  // APB: always ready, write on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {{(32 - SIZE_W){1'b0}}, map_height_r}
                                   : {{(32 - SIZE_W){1'b0}}, map_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= SIZE_W'(64);
      map_height_r <= SIZE_W'(64);
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        map_height_r <= cfg_pwdata[SIZE_W-1:0];
      end else begin
        map_width_r <= cfg_pwdata[SIZE_W-1:0];
      end
    end
  end

  // Sizes above the grid act as the grid
  assign w_eff = (EW'(map_width_r) > EW'(GRID_SIZE)) ? EW'(GRID_SIZE) : EW'(map_width_r);
  assign h_eff = (EW'(map_height_r) > EW'(GRID_SIZE)) ? EW'(GRID_SIZE) : EW'(map_height_r);

  // One DDA step: advance along the axis whose boundary is nearer.
  // y steps flipped: a negative dir_y moves to higher rows.
  always_comb begin
    take_x   = side_x_r < side_y_r;
    nmx      = mx_r;
    nmy      = my_r;
    if (take_x) begin
      nmx = dx_neg_r ? mx_r - 1'b1 : mx_r + 1'b1;
    end else begin
      nmy = dy_neg_r ? my_r + 1'b1 : my_r - 1'b1;
    end
    n_out    = $signed(nmx) < 0 || $signed(nmy) < 0 ||
               $signed(nmx) >= $signed({1'b0, w_eff}) ||
               $signed(nmy) >= $signed({1'b0, h_eff});
    at_limit = n_r == NW'(MAX_STEPS);
    out_free = !out_valid_r || out_tready;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:      if (in_acc && in_tuser == FUNC_CAST) state_nxt = S_DIVX_GO;
      S_DIVX_GO:   state_nxt = S_DIVX_WAIT;
      S_DIVX_WAIT: if (!div_busy) state_nxt = S_DIVY_GO;
      S_DIVY_GO:   state_nxt = S_DIVY_WAIT;
      S_DIVY_WAIT: if (!div_busy) state_nxt = S_MUL;
      S_MUL:       if (mcnt_r == 3'd4) state_nxt = S_START;
      S_START: begin
        if ($signed(mx_r) >= $signed({1'b0, w_eff}) ||
            $signed(my_r) >= $signed({1'b0, h_eff})) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK:      state_nxt = (at_limit || n_out) ? S_DONE : S_TEST;
      S_TEST:      state_nxt = ram_rdata ? S_DONE : S_WALK;
      S_DONE:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    div_mag   = adx_r;
    ram_we    = 1'b0;
    ram_waddr = AW'(clr_r);
    ram_wdata = 1'b0;
    unique case (state_r)
      S_CLEAR: ram_we = 1'b1;
      S_IDLE: begin
        in_tready = 1'b1;
        ram_waddr = AW'(AW'(f_cy) * AW'(GRID_SIZE) + AW'(f_cx));
        ram_wdata = f_wall;
        ram_we    = in_acc && in_tuser == FUNC_WRITE &&
                    int'(f_cx) < GRID_SIZE && int'(f_cy) < GRID_SIZE;
      end
      S_DIVX_GO: div_start = 1'b1;
      S_DIVY_GO: begin
        div_start = 1'b1;
        div_mag   = ady_r;
      end
      default: ;
    endcase
    ram_raddr = AW'(AW'(nmy[CW-2:0]) * AW'(GRID_SIZE) + AW'(nmx[CW-2:0]));
  end

  // Multiplier operand select: fraction to the first boundary times
  // high then low half of each delta
  always_comb begin
    frac_x = dx_neg_r ? {1'b0, fx_r} : ONE_FIX - {1'b0, fx_r};
    frac_y = dy_neg_r ? ONE_FIX - {1'b0, fy_r} : {1'b0, fy_r};
    mul_a  = '0;
    mul_b  = '0;
    unique case (mcnt_r)
      3'd0: begin
        mul_a = frac_x;
        mul_b = FRAC_W'(delta_x_r[QUO_W-1:FRAC_BITS]);
      end
      3'd1: begin
        mul_a = frac_x;
        mul_b = FRAC_W'(delta_x_r[FRAC_BITS-1:0]);
      end
      3'd2: begin
        mul_a = frac_y;
        mul_b = FRAC_W'(delta_y_r[QUO_W-1:FRAC_BITS]);
      end
      3'd3: begin
        mul_a = frac_y;
        mul_b = FRAC_W'(delta_y_r[FRAC_BITS-1:0]);
      end
      default: ;
    endcase
  end

  // Distance: back off the last step; a cast that starts off the map reports 0
  always_comb begin
    dist_raw = side_r ? side_y_r - SIDE_W'(delta_y_r) : side_x_r - SIDE_W'(delta_x_r);
    if (n_r == '0) begin
      dist_sat = '0;
    end else if (dist_raw > SIDE_W'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = dist_raw[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        // latch the cast request
        mx_r      <= CW'(f_px[POS_W-1:FRAC_BITS]);
        my_r      <= CW'(f_py[POS_W-1:FRAC_BITS]);
        fx_r      <= f_px[FRAC_BITS-1:0];
        fy_r      <= f_py[FRAC_BITS-1:0];
        dx_neg_r  <= f_dx[DIR_W-1];
        dy_neg_r  <= f_dy[DIR_W-1];
        dx_zero_r <= f_dx == '0;
        dy_zero_r <= f_dy == '0;
        adx_r     <= f_dx[DIR_W-1] ? MAG_W'(-f_dx) : f_dx;
        ady_r     <= f_dy[DIR_W-1] ? MAG_W'(-f_dy) : f_dy;
        side_r    <= 1'b0;
        n_r       <= '0;
        mcnt_r    <= '0;
        status_r  <= STAT_EXIT;
      end
      S_DIVX_WAIT: begin
        if (dy_zero_r) begin
          delta_x_r <= '0;
        end else if (dx_zero_r) begin
          delta_x_r <= QUO_W'(ONE_FIX);
        end else begin
          delta_x_r <= div_quo;
        end
      end
      S_DIVY_WAIT: begin
        if (dx_zero_r) begin
          delta_y_r <= '0;
        end else if (dy_zero_r) begin
          delta_y_r <= QUO_W'(ONE_FIX);
        end else begin
          delta_y_r <= div_quo;
        end
      end
      S_MUL: begin
        prod_r <= mul_a * mul_b;
        mcnt_r <= mcnt_r + 1'b1;
        unique case (mcnt_r)
          3'd1: side_x_r <= SIDE_W'(prod_r);
          3'd2: side_x_r <= side_x_r + SIDE_W'(prod_r >> FRAC_BITS);
          3'd3: side_y_r <= SIDE_W'(prod_r);
          3'd4: side_y_r <= side_y_r + SIDE_W'(prod_r >> FRAC_BITS);
          default: ;
        endcase
      end
      S_WALK: begin
        if (at_limit) begin
          status_r <= STAT_LIMIT;
        end else begin
          n_r  <= n_r + 1'b1;
          mx_r <= nmx;
          my_r <= nmy;
          if (take_x) begin
            side_x_r <= side_x_r + SIDE_W'(delta_x_r);
            side_r   <= 1'b0;
          end else begin
            side_y_r <= side_y_r + SIDE_W'(delta_y_r);
            side_r   <= 1'b1;
          end
          status_r <= STAT_EXIT;
        end
      end
      S_TEST: begin
        status_r <= ram_rdata ? STAT_HIT : STAT_LIMIT;
      end
      S_DONE: begin
        if (out_free) begin
          out_data_r <= OUT_TDATA_W'({my_r[CELL_W-1:0], mx_r[CELL_W-1:0], side_r, dist_sat});
          out_user_r <= status_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  gdda_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (div_mag),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  gdda_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ rtl/gdda_ram.sv @@
module gdda_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/gdda_recip.sv @@
// Restoring divider: quo = 2^(2*FRAC_BITS) / mag, one quotient bit per cycle.
module gdda_recip import gdda_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MAG_W-1:0] mag,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [MAG_W:0]   trial;
  logic             fits;

  always_comb begin
    // the dividend has a single one at its top bit
    trial    = {rem_r, (cnt_r == CNT_W'(QUO_W - 1))};
    fits     = trial >= {1'b0, mag_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    mag_nxt  = mag_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = '0;
      mag_nxt  = mag;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? MAG_W'(trial - {1'b0, mag_r}) : MAG_W'(trial);
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule
